/* rtl/core/fiss_pkg.sv */
// Package for the flex instance split search block.
// Widths, fixed-point constants and the reciprocal used by the step decay.
// No dependencies.
`default_nettype none

package fiss_pkg;

    localparam int CNT_W   = 7;                 // instance counts
    localparam int AB_W    = 32;                // abilities, Q16.16
    localparam int X_W     = 31;                // flex ratio, 1.0 = 2^30
    localparam int Q_SH    = 30;                // ratio fraction bits
    localparam int THR_W   = 48;                // result throughput
    localparam int BASE_W  = CNT_W + AB_W;      // count * ability
    localparam int TP_W    = BASE_W + 1;        // base plus flex share
    localparam int REM_W   = CNT_W + AB_W + 1;  // divider remainder
    localparam int DEN_W   = AB_W + 1;          // mp + md
    localparam int LIM_W   = 10;
    localparam int STEP_W  = 27;
    localparam int PROD_W  = 2 * AB_W;
    localparam int DCNT_W  = $clog2(CNT_W);

    localparam logic [X_W-1:0]    ONE_Q30     = X_W'(1073741824);
    localparam logic [X_W-1:0]    HALF_Q30    = X_W'(536870912);
    localparam logic [STEP_W-1:0] FIRST_STEP  = STEP_W'(107374182);
    localparam logic [LIM_W-1:0]  LIMIT_RESET = LIM_W'(1000);

    // floor(s/100) == (s * RECIP_100) >> RECIP_SH for every s below 2^30
    localparam logic [AB_W-1:0]   RECIP_100   = AB_W'(171798692);
    localparam int                RECIP_SH    = 34;

    localparam int FISS_MAX_INST = 64;

endpackage

`default_nettype wire

/* rtl/core/fiss_if.sv */
// Valid/ready channel interfaces for the flex instance split search block.
// Depends on fiss_pkg for field widths.
`default_nettype none

interface fiss_in_if;
    import fiss_pkg::*;

    logic              valid;
    logic              ready;
    logic [AB_W-1:0]   prefill_ability;
    logic [AB_W-1:0]   decode_ability;
    logic [AB_W-1:0]   cap_ability;
    logic [CNT_W-1:0]  total_instances;
    logic [CNT_W-1:0]  flex_instances;
    logic [X_W-1:0]    start_ratio;

    modport source (
        output valid, prefill_ability, decode_ability, cap_ability,
               total_instances, flex_instances, start_ratio,
        input  ready
    );
    modport sink (
        input  valid, prefill_ability, decode_ability, cap_ability,
               total_instances, flex_instances, start_ratio,
        output ready
    );
endinterface

interface fiss_out_if;
    import fiss_pkg::*;

    logic              valid;
    logic              ready;
    logic              status;
    logic [CNT_W-1:0]  prefill_count;
    logic [CNT_W-1:0]  decode_count;
    logic [X_W-1:0]    flex_ratio;
    logic [THR_W-1:0]  best_throughput;

    modport source (
        output valid, status, prefill_count, decode_count, flex_ratio,
               best_throughput,
        input  ready
    );
    modport sink (
        input  valid, status, prefill_count, decode_count, flex_ratio,
               best_throughput,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/flex_instance_split_search.sv */
// Flex instance split search: one item in, one result out, over one shared multiplier.
// Sequence: a product and a 7-step divide, then per candidate count (floor, then ceiling)
// a setup and R search rounds, R at most iteration_limit.
// Throughput: one item at a time; the multiplier is busy in every round cycle.
// Reset (i_rst_n low, synchronous): idle, no result pending, iteration_limit = 1000.
// Depends on fiss_pkg and fiss_if.
`default_nettype none

module flex_instance_split_search #(
    parameter int MAX_INSTANCES = fiss_pkg::FISS_MAX_INST
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [fiss_pkg::LIM_W-1:0]  i_cfg_wdata,
    fiss_in_if.sink                    i_in,
    fiss_out_if.source                 o_out
);
    import fiss_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_NUM   = 12'b0000_0000_0010,
        S_DIV   = 12'b0000_0000_0100,
        S_CAND  = 12'b0000_0000_1000,
        S_BASEP = 12'b0000_0001_0000,
        S_BASED = 12'b0000_0010_0000,
        S_RA    = 12'b0000_0100_0000,
        S_RB    = 12'b0000_1000_0000,
        S_RC    = 12'b0001_0000_0000,
        S_FIN   = 12'b0010_0000_0000,
        S_PICK  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [LIM_W-1:0]    r_limit, n_limit;
    logic [AB_W-1:0]     r_pa, n_pa, r_da, n_da, r_ta, n_ta, r_mp, n_mp, r_md, n_md;
    logic [CNT_W-1:0]    r_total, n_total, r_flex, n_flex;
    logic [X_W-1:0]      r_x0, n_x0;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0]    r_lo, n_lo;
    logic [DCNT_W-1:0]   r_div_cnt, n_div_cnt;
    logic                r_first, n_first;
    logic                r_cand, n_cand;
    logic [CNT_W-1:0]    r_pc, n_pc, r_dc, n_dc;
    logic [X_W-1:0]      r_x, n_x;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [LIM_W-1:0]    r_iter, n_iter;
    logic [TP_W-1:0]     r_tp, n_tp, r_thr, n_thr;
    logic [BASE_W-1:0]   r_basep, n_basep, r_based, n_based;
    logic [CNT_W-1:0]    r_bpc, n_bpc, r_bdc, n_bdc;
    logic [X_W-1:0]      r_bx, n_bx;
    logic [TP_W-1:0]     r_bthr, n_bthr;
    logic                r_o_status, n_o_status;
    logic [CNT_W-1:0]    r_o_pc, n_o_pc, r_o_dc, n_o_dc;
    logic [X_W-1:0]      r_o_x, n_o_x;
    logic [THR_W-1:0]    r_o_thr, n_o_thr;

    // shared multiplier
    logic [AB_W-1:0]     mul_a, mul_b;
    logic [PROD_W-1:0]   mul_p;

    // datapath helpers
    logic [AB_W-1:0]     in_mp, in_md;
    logic [DEN_W-1:0]    den;
    logic [REM_W-1:0]    rem_cur, trial;
    logic [CNT_W-1:0]    pc_cand, dc_cand;
    logic                over;
    logic [AB_W-1:0]     share, share_min;
    logic [TP_W-1:0]     td, thr_now;
    logic [STEP_W-1:0]   step_q;
    logic [X_W-1:0]      step_x, x_dn, x_up, x_fin;
    logic [X_W:0]        x_sum;
    logic [LIM_W:0]      iter_inc;

    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_NUM: begin
                mul_a = AB_W'(r_total);
                mul_b = r_md;
            end
            S_CAND: begin
                mul_a = AB_W'(pc_cand);
                mul_b = r_mp;
            end
            S_BASEP: begin
                mul_a = AB_W'(r_dc);
                mul_b = r_md;
            end
            S_RA: begin
                mul_a = AB_W'(r_x);
                mul_b = r_pa;
            end
            S_RB: begin
                mul_a = AB_W'(ONE_Q30 - r_x);
                mul_b = r_da;
            end
            S_RC: begin
                mul_a = AB_W'(r_step);
                mul_b = RECIP_100;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign in_mp = (i_in.prefill_ability < i_in.cap_ability) ? i_in.prefill_ability
                                                              : i_in.cap_ability;
    assign in_md = (i_in.decode_ability < i_in.cap_ability) ? i_in.decode_ability
                                                             : i_in.cap_ability;

    // restoring divide, one quotient bit per cycle
    assign den     = {1'b0, r_mp} + {1'b0, r_md};
    assign rem_cur = r_first ? r_prod[REM_W-1:0] : r_rem;
    assign trial   = REM_W'(den) << r_div_cnt;

    // ceiling count is floor plus one when the division left a remainder
    assign pc_cand = r_cand ? CNT_W'(r_lo + CNT_W'(r_rem != '0)) : r_lo;
    assign over    = ({1'b0, pc_cand} + {1'b0, r_flex}) > {1'b0, r_total};
    assign dc_cand = r_total - pc_cand - r_flex;

    // flex share of the product in r_prod, capped at t
    assign share     = r_prod[Q_SH +: AB_W];
    assign share_min = (share < r_ta) ? share : r_ta;
    assign td        = TP_W'(r_based) + TP_W'(share_min);
    assign thr_now   = (r_tp < td) ? r_tp : td;

    assign step_q   = r_prod[RECIP_SH +: STEP_W];
    assign step_x   = X_W'(r_step);
    assign x_dn     = (r_x > step_x) ? r_x - step_x : '0;
    assign x_sum    = {1'b0, r_x} + {1'b0, step_x};
    assign x_up     = (x_sum > {1'b0, ONE_Q30}) ? ONE_Q30 : x_sum[X_W-1:0];
    assign iter_inc = {1'b0, r_iter} + 1'b1;

    always_comb begin
        x_fin = r_x;
        if ((r_pc == '0) && (r_x < HALF_Q30)) begin
            x_fin = HALF_Q30;
        end else if ((r_dc == '0) && (r_x > HALF_Q30)) begin
            x_fin = HALF_Q30;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_limit    = i_cfg_we ? i_cfg_wdata : r_limit;
        n_pa       = r_pa;
        n_da       = r_da;
        n_ta       = r_ta;
        n_mp       = r_mp;
        n_md       = r_md;
        n_total    = r_total;
        n_flex     = r_flex;
        n_x0       = r_x0;
        n_prod     = r_prod;
        n_rem      = r_rem;
        n_lo       = r_lo;
        n_div_cnt  = r_div_cnt;
        n_first    = r_first;
        n_cand     = r_cand;
        n_pc       = r_pc;
        n_dc       = r_dc;
        n_x        = r_x;
        n_step     = r_step;
        n_iter     = r_iter;
        n_tp       = r_tp;
        n_thr      = r_thr;
        n_basep    = r_basep;
        n_based    = r_based;
        n_bpc      = r_bpc;
        n_bdc      = r_bdc;
        n_bx       = r_bx;
        n_bthr     = r_bthr;
        n_o_status = r_o_status;
        n_o_pc     = r_o_pc;
        n_o_dc     = r_o_dc;
        n_o_x      = r_o_x;
        n_o_thr    = r_o_thr;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_pa    = i_in.prefill_ability;
                    n_da    = i_in.decode_ability;
                    n_ta    = i_in.cap_ability;
                    n_mp    = in_mp;
                    n_md    = in_md;
                    n_total = (int'(i_in.total_instances) > MAX_INSTANCES)
                              ? CNT_W'(MAX_INSTANCES) : i_in.total_instances;
                    n_flex  = (int'(i_in.flex_instances) > MAX_INSTANCES)
                              ? CNT_W'(MAX_INSTANCES) : i_in.flex_instances;
                    n_x0    = (i_in.start_ratio > ONE_Q30) ? ONE_Q30 : i_in.start_ratio;
                    if ((i_in.prefill_ability == '0) || (i_in.decode_ability == '0) ||
                        (i_in.cap_ability == '0)) begin
                        n_o_status = 1'b1;
                        n_o_pc     = '0;
                        n_o_dc     = '0;
                        n_o_x      = '0;
                        n_o_thr    = '0;
                        n_state    = S_OUT;
                    end else begin
                        n_state = S_NUM;
                    end
                end
            end
            S_NUM: begin
                n_prod    = mul_p;
                n_first   = 1'b1;
                n_lo      = '0;
                n_div_cnt = DCNT_W'(CNT_W - 1);
                n_state   = S_DIV;
            end
            S_DIV: begin
                n_first = 1'b0;
                if (rem_cur >= trial) begin
                    n_rem            = rem_cur - trial;
                    n_lo[r_div_cnt]  = 1'b1;
                end else begin
                    n_rem = rem_cur;
                end
                if (r_div_cnt == '0) begin
                    n_cand  = 1'b0;
                    n_state = S_CAND;
                end else begin
                    n_div_cnt = r_div_cnt - 1'b1;
                end
            end
            S_CAND: begin
                n_pc  = pc_cand;
                n_thr = '0;
                if (over) begin
                    // too many prefill instances: no search, no ratio adjustment
                    n_dc    = '0;
                    n_x     = '0;
                    n_state = S_PICK;
                end else begin
                    n_dc    = dc_cand;
                    n_x     = r_x0;
                    n_step  = FIRST_STEP;
                    n_iter  = '0;
                    n_prod  = mul_p;
                    n_state = S_BASEP;
                end
            end
            S_BASEP: begin
                n_basep = r_prod[BASE_W-1:0];
                n_prod  = mul_p;
                n_state = S_BASED;
            end
            S_BASED: begin
                n_based = r_prod[BASE_W-1:0];
                n_first = 1'b1;
                n_state = (r_limit == '0) ? S_FIN : S_RA;
            end
            S_RA: begin
                // apply the step decay computed in the previous round
                if (!r_first) begin
                    n_step = r_step - step_q;
                end
                n_first = 1'b0;
                n_prod  = mul_p;
                n_state = S_RB;
            end
            S_RB: begin
                n_tp    = TP_W'(r_basep) + TP_W'(share_min);
                n_prod  = mul_p;
                n_state = S_RC;
            end
            S_RC: begin
                n_thr  = thr_now;
                n_prod = mul_p;
                if (r_tp == td) begin
                    n_state = S_FIN;
                end else begin
                    n_x     = (r_tp > td) ? x_dn : x_up;
                    n_iter  = iter_inc[LIM_W-1:0];
                    n_state = (iter_inc == {1'b0, r_limit}) ? S_FIN : S_RA;
                end
            end
            S_FIN: begin
                n_x     = x_fin;
                n_state = S_PICK;
            end
            S_PICK: begin
                if (!r_cand) begin
                    n_bpc   = r_pc;
                    n_bdc   = r_dc;
                    n_bx    = r_x;
                    n_bthr  = r_thr;
                    n_cand  = 1'b1;
                    n_state = S_CAND;
                end else begin
                    n_o_status = 1'b0;
                    // floor count wins only on strictly larger throughput
                    if (r_bthr > r_thr) begin
                        n_o_pc  = r_bpc;
                        n_o_dc  = r_bdc;
                        n_o_x   = r_bx;
                        n_o_thr = THR_W'(r_bthr);
                    end else begin
                        n_o_pc  = r_pc;
                        n_o_dc  = r_dc;
                        n_o_x   = r_x;
                        n_o_thr = THR_W'(r_thr);
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_limit <= n_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa       <= n_pa;
        r_da       <= n_da;
        r_ta       <= n_ta;
        r_mp       <= n_mp;
        r_md       <= n_md;
        r_total    <= n_total;
        r_flex     <= n_flex;
        r_x0       <= n_x0;
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_lo       <= n_lo;
        r_div_cnt  <= n_div_cnt;
        r_first    <= n_first;
        r_cand     <= n_cand;
        r_pc       <= n_pc;
        r_dc       <= n_dc;
        r_x        <= n_x;
        r_step     <= n_step;
        r_iter     <= n_iter;
        r_tp       <= n_tp;
        r_thr      <= n_thr;
        r_basep    <= n_basep;
        r_based    <= n_based;
        r_bpc      <= n_bpc;
        r_bdc      <= n_bdc;
        r_bx       <= n_bx;
        r_bthr     <= n_bthr;
        r_o_status <= n_o_status;
        r_o_pc     <= n_o_pc;
        r_o_dc     <= n_o_dc;
        r_o_x      <= n_o_x;
        r_o_thr    <= n_o_thr;
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = (r_state == S_OUT);
    assign o_out.status          = r_o_status;
    assign o_out.prefill_count   = r_o_pc;
    assign o_out.decode_count    = r_o_dc;
    assign o_out.flex_ratio      = r_o_x;
    assign o_out.best_throughput = r_o_thr;

    // a pending result blocks new input
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while result pending");

    // zero ability results carry zero payload
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |->
            (o_out.prefill_count == '0 && o_out.decode_count == '0 &&
             o_out.flex_ratio == '0 && o_out.best_throughput == '0))
        else $error("status result with nonzero payload");

    // the search keeps the ratio within [0, 1.0]
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RA) |-> (r_x <= ONE_Q30))
        else $error("flex ratio above one during search");

    // a round ends either by balance, by the limit, or moves on to the next round
    a_round_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RC) |=> (r_state == S_RA || r_state == S_FIN))
        else $error("search round left to an unexpected state");

endmodule

`default_nettype wire

/* test/flex_instance_split_search_tb.sv */
// Testbench for flex_instance_split_search: directed and random items over valid/ready channels.
// A scoreboard class predicts each split decision and checks it against the result channel.
// Depends on fiss_pkg, fiss_if and the RTL top level.
`default_nettype none

module flex_instance_split_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fiss_pkg::*;

    typedef struct packed {
        logic [AB_W-1:0]  prefill;
        logic [AB_W-1:0]  decode;
        logic [AB_W-1:0]  cap;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] flex;
        logic [X_W-1:0]   ratio;
    } t_split_request;

    typedef struct packed {
        logic             status;
        logic [CNT_W-1:0] pcount;
        logic [CNT_W-1:0] dcount;
        logic [X_W-1:0]   ratio;
        logic [THR_W-1:0] thr;
    } t_split_decision;

    typedef struct {
        bit [63:0] pc;
        bit [63:0] dc;
        bit [63:0] x;
        bit [63:0] thr;
    } t_count_outcome;

    class split_scoreboard;
        t_split_decision pending[$];
        bit [LIM_W-1:0]  rounds_limit;
        int              errors;

        function new();
            rounds_limit = LIMIT_RESET;
            errors = 0;
        endfunction

        function void set_limit(bit [LIM_W-1:0] v);
            rounds_limit = v;
        endfunction

        function bit [63:0] min64(bit [63:0] a, bit [63:0] b);
            return (a < b) ? a : b;
        endfunction

        // Balance search for one prefill count.
        function t_count_outcome search_count(bit [63:0] pc, bit [63:0] total,
                                              bit [63:0] flex, bit [63:0] pa,
                                              bit [63:0] da, bit [63:0] ta,
                                              bit [63:0] x0);
            t_count_outcome c;
            bit [63:0] mp, md, x, step, tp, td, one, half;
            int i;
            one  = 64'(ONE_Q30);
            half = 64'(HALF_Q30);
            mp = min64(pa, ta);
            md = min64(da, ta);
            c.pc = pc;
            if (pc + flex > total) begin
                c.dc = 0;
                c.x = 0;
                c.thr = 0;
                return c;
            end
            c.dc = total - pc - flex;
            x = x0;
            step = 64'(FIRST_STEP);
            tp = 0;
            td = 0;
            for (i = 0; i < int'(rounds_limit); i++) begin
                tp = pc * mp + min64((x * pa) >> Q_SH, ta);
                td = c.dc * md + min64(((one - x) * da) >> Q_SH, ta);
                if (tp == td)
                    break;
                if (tp > td)
                    x = (x > step) ? x - step : 64'd0;
                else
                    x = min64(x + step, one);
                step = step - step / 100;
            end
            c.thr = min64(tp, td);
            if (pc == 0 && x < half)
                x = half;
            if (c.dc == 0 && x > half)
                x = half;
            c.x = x;
            return c;
        endfunction

        function void note_request(t_split_request r);
            t_split_decision d;
            t_count_outcome  lo_c, hi_c, best;
            bit [63:0] pa, da, ta, total, flex, x0, mp, md, num, den, lo, hi;
            pa = 64'(r.prefill);
            da = 64'(r.decode);
            ta = 64'(r.cap);
            total = min64(64'(r.total), 64'(FISS_MAX_INST));
            flex  = min64(64'(r.flex), 64'(FISS_MAX_INST));
            x0    = min64(64'(r.ratio), 64'(ONE_Q30));
            d = '0;
            if (pa == 0 || da == 0 || ta == 0) begin
                d.status = 1'b1;
                pending.push_back(d);
                return;
            end
            mp = min64(pa, ta);
            md = min64(da, ta);
            num = total * md;
            den = mp + md;
            lo = num / den;
            hi = lo + ((num % den) != 0 ? 64'd1 : 64'd0);
            lo_c = search_count(lo, total, flex, pa, da, ta, x0);
            hi_c = search_count(hi, total, flex, pa, da, ta, x0);
            // the floor count must win strictly
            best = (lo_c.thr > hi_c.thr) ? lo_c : hi_c;
            d.pcount = best.pc[CNT_W-1:0];
            d.dcount = best.dc[CNT_W-1:0];
            d.ratio  = best.x[X_W-1:0];
            d.thr    = best.thr[THR_W-1:0];
            pending.push_back(d);
        endfunction

        function void compare_field(string name, bit [63:0] e, bit [63:0] a);
            if (e != a) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_decision(t_split_decision got);
            t_split_decision exp;
            if (pending.size() == 0) begin
                $display({"%0t: unexpected result, expected none, ",
                          "actual status %0d p %0d d %0d x %0d thr %0d"},
                         $time, got.status, got.pcount, got.dcount, got.ratio, got.thr);
                errors++;
                return;
            end
            exp = pending.pop_front();
            compare_field("status", 64'(exp.status), 64'(got.status));
            compare_field("prefill_count", 64'(exp.pcount), 64'(got.pcount));
            compare_field("decode_count", 64'(exp.dcount), 64'(got.dcount));
            compare_field("flex_ratio", 64'(exp.ratio), 64'(got.ratio));
            compare_field("best_throughput", 64'(exp.thr), 64'(got.thr));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LIM_W-1:0]   i_cfg_wdata;

    fiss_in_if  in_ch ();
    fiss_out_if out_ch ();

    flex_instance_split_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    split_scoreboard ledger;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: check every transfer, then pick ready for the next edge.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                ledger.check_decision('{status: out_ch.status,
                                        pcount: out_ch.prefill_count,
                                        dcount: out_ch.decode_count,
                                        ratio:  out_ch.flex_ratio,
                                        thr:    out_ch.best_throughput});
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_request(input t_split_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.prefill_ability <= r.prefill;
        in_ch.decode_ability  <= r.decode;
        in_ch.cap_ability     <= r.cap;
        in_ch.total_instances <= r.total;
        in_ch.flex_instances  <= r.flex;
        in_ch.start_ratio     <= r.ratio;
        do @(posedge i_clk); while (!in_ch.ready);
        ledger.note_request(r);
    endtask

    task automatic send_fields(input logic [AB_W-1:0] p, input logic [AB_W-1:0] d,
                               input logic [AB_W-1:0] t, input logic [CNT_W-1:0] total,
                               input logic [CNT_W-1:0] flex, input logic [X_W-1:0] x);
        send_request('{prefill: p, decode: d, cap: t, total: total, flex: flex, ratio: x});
    endtask

    // Drop valid and hold until every result is back, plus a short tail.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (ledger.pending.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ledger.set_limit(v);
    endtask

    function automatic logic [AB_W-1:0] pick_ability(bit allow_zero);
        int sel;
        logic [AB_W-1:0] v;
        sel = $urandom_range(6);
        if (allow_zero && $urandom_range(3) == 0)
            return '0;
        case (sel)
            0: v = 32'hFFFF_FFFF;
            1: v = $urandom_range(16, 1);
            2: v = $urandom_range(32'h0002_0000, 32'h0000_0100);
            3: v = 32'h0001_0000 << $urandom_range(15);
            default: v = $urandom;
        endcase
        if (v == 0)
            v = 1;
        return v;
    endfunction

    // Mostly well-formed items that reach the search; the rest is noise.
    function automatic t_split_request make_request();
        t_split_request r;
        int sel;
        if ($urandom_range(99) < 85) begin
            r.prefill = pick_ability(1'b0);
            r.decode  = pick_ability(1'b0);
            r.cap     = pick_ability(1'b0);
            r.total   = CNT_W'($urandom_range(64, 1));
            r.flex    = CNT_W'($urandom_range(r.total / 2));
            sel = $urandom_range(9);
            if (sel == 0)
                r.ratio = '0;
            else if (sel == 1)
                r.ratio = ONE_Q30;
            else
                r.ratio = X_W'($urandom_range(ONE_Q30));
        end else begin
            r.prefill = pick_ability(1'b1);
            r.decode  = pick_ability(1'b1);
            r.cap     = pick_ability(1'b1);
            r.total   = CNT_W'($urandom_range(127));
            r.flex    = CNT_W'($urandom_range(127));
            r.ratio   = X_W'($urandom);
        end
        return r;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_request(make_request());
    endtask

    initial begin
        ledger = new();
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.prefill_ability <= '0;
        in_ch.decode_ability  <= '0;
        in_ch.cap_ability     <= '0;
        in_ch.total_instances <= '0;
        in_ch.flex_instances  <= '0;
        in_ch.start_ratio     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at the reset limit, no idling.
        send_fields(32'h0, 32'h0, 32'h0, 7'd8, 7'd2, HALF_Q30);
        send_fields(32'h0, 32'h1_0000, 32'h1_0000, 7'd8, 7'd2, HALF_Q30);
        send_fields(32'h1_0000, 32'h0, 32'h1_0000, 7'd8, 7'd2, HALF_Q30);
        send_fields(32'h1_0000, 32'h1_0000, 32'h0, 7'd8, 7'd2, HALF_Q30);
        // balanced at the first round
        send_fields(32'h1_0000, 32'h1_0000, 32'h1_0000, 7'd2, 7'd0, HALF_Q30);
        // both counts too large
        send_fields(32'h1_0000, 32'h1_0000, 32'h2_0000, 7'd4, 7'd4, HALF_Q30);
        send_fields(32'h2_0000, 32'h2_0000, 32'h2_0000, 7'd12, 7'd12, HALF_Q30);
        // counts above the maximum saturate
        send_fields(32'h3_0000, 32'h1_0000, 32'h4_0000, 7'd127, 7'd127, HALF_Q30);
        send_fields(32'h3_0000, 32'h1_0000, 32'h4_0000, 7'd127, 7'd3, HALF_Q30);
        // start ratio above one saturates
        send_fields(32'h1_8000, 32'h2_4000, 32'h3_0000, 7'd10, 7'd2, 31'h7FFF_FFFF);
        send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd64, 7'd0, 31'h0);
        // no prefill instances, then no decode instances
        send_fields(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 7'd5, 7'd0, 31'h0);
        send_fields(32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd5, 7'd0, ONE_Q30);
        send_fields(32'h1_0000, 32'h2_0000, 32'h1_8000, 7'd0, 7'd0, HALF_Q30);
        // cap below both abilities
        send_fields(32'h8_0000, 32'h5_0000, 32'h8000, 7'd20, 7'd6, 31'h1000_0000);
        send_fields(32'h1_2345, 32'h2_3456, 32'h3_0000, 7'd33, 7'd5, 31'h0);
        send_fields(32'h2_3456, 32'h1_2345, 32'h3_0000, 7'd33, 7'd5, ONE_Q30);
        send_fields(32'h1, 32'h1, 32'h1, 7'd64, 7'd0, HALF_Q30);

        // Largest limit, few items.
        write_limit(10'd1023);
        run_random(3);

        // No rounds at all.
        write_limit(10'd0);
        run_random(6);

        write_limit(10'd1);
        send_idle_pct = 70;
        stall_pct = 0;
        run_random(30);

        // Hold results off while items keep coming so the input stalls.
        write_limit(10'd12);
        send_idle_pct = 0;
        stall_pct = 70;
        hold_cycles = 3000;
        run_random(60);

        write_limit(10'd40);
        send_idle_pct = 8;
        stall_pct = 8;
        run_random(30);
        wait_drained();
        run_random(30);

        write_limit(10'd100);
        send_idle_pct = 0;
        stall_pct = 0;
        run_random(60);

        write_limit(10'd5);
        send_idle_pct = 30;
        stall_pct = 30;
        run_random(50);

        wait_drained();
        if (ledger.errors == 0 && ledger.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
